### sv/fdr_pkg.sv
// shared types and constants for the dielectric fresnel reflectance pipeline
package fdr_pkg;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;
    localparam int Q_W         = 31;

    localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
    localparam logic [15:0] REFL_ONE = 16'd32768;

    localparam logic [15:0] ETA_INCIDENT_RST    = 16'd4096;
    localparam logic [15:0] ETA_TRANSMITTED_RST = 16'd6144;

    // register index, taken from paddr[2]
    localparam logic REG_ETA_INCIDENT    = 1'b0;
    localparam logic REG_ETA_TRANSMITTED = 1'b1;

    // side data that rides along the square root pipeline
    typedef struct packed {
        logic        valid;
        logic        tir;
        logic [32:0] p1;
        logic [48:0] p2;
        logic [15:0] ni;
    } sqrt_sb_t;

    // side data that rides along the divider pipelines
    typedef struct packed {
        logic valid;
        logic tir;
        logic z1;
        logic z2;
    } div_sb_t;

endpackage

### sv/fresnel_dielectric_reflectance_top.sv
// top level of the unpolarized dielectric fresnel reflectance pipeline
// Takes one signed cosine request per cycle and returns one reflectance per
// request, in order. The pipeline is 12 front and back stages plus a 32-stage
// square root and a 31-stage divider, and it takes one request per cycle
// whenever it is not held by a stalled output; each result appears at the
// output register. The whole pipeline advances together and holds only
// while the output register is full and stalled, so cos_stall simply mirrors
// that condition. The two refractive indices sit behind an APB-style port at
// byte addresses 0 (incident) and 4 (transmitted); change them only while no
// request is in flight. Total internal reflection returns 32768 with the flag.
module fresnel_dielectric_reflectance_top
    import fdr_pkg::*;
#(
    parameter int COS_FRAC_BITS = 15
)
(
    input  logic        clk,
    input  logic        rst_n,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request side
    input  logic        cos_valid,
    output logic        cos_stall,
    input  logic [15:0] cos_theta,
    // result side
    output logic        refl_valid,
    input  logic        refl_stall,
    output logic [15:0] reflectance,
    output logic        total_internal
);

    localparam logic signed [25:0] COS_ONE = 26'sd1 <<< COS_FRAC_BITS;
    localparam int UP_SH = (COS_FRAC_BITS < 16) ? 16 - COS_FRAC_BITS : 0;
    localparam int DN_SH = (COS_FRAC_BITS >= 16) ? COS_FRAC_BITS - 16 : 0;

    // ---------------- configuration registers ----------------
    logic [15:0] eta_i_reg;
    logic [15:0] eta_t_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_i_reg <= ETA_INCIDENT_RST;
            eta_t_reg <= ETA_TRANSMITTED_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                REG_ETA_INCIDENT:    eta_i_reg <= pwdata[15:0];
                REG_ETA_TRANSMITTED: eta_t_reg <= pwdata[15:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ETA_INCIDENT:    prdata = {16'b0, eta_i_reg};
            REG_ETA_TRANSMITTED: prdata = {16'b0, eta_t_reg};
            default:             prdata = '0;
        endcase
    end

    // ---------------- global advance ----------------
    // everything moves unless a finished result is waiting and stalled
    logic out_valid_reg;
    logic en;

    assign en        = !(out_valid_reg && refl_stall);
    assign cos_stall = !en;

    // ---------------- stage 1: clamp, direction, rescale ----------------
    logic signed [25:0] cs_ext;
    logic signed [25:0] cs_clamp;
    logic [25:0]        mag;
    logic [33:0]        c_wide;
    logic [16:0]        c_next;
    logic               entering;

    always_comb
    begin
        cs_ext = 26'(signed'(cos_theta));
        if (cs_ext > COS_ONE)
            cs_clamp = COS_ONE;
        else if (cs_ext < -COS_ONE)
            cs_clamp = -COS_ONE;
        else
            cs_clamp = cs_ext;
        // zero counts as leaving
        entering = (cs_clamp > 26'sd0);
        mag      = entering ? 26'(cs_clamp) : 26'(-cs_clamp);
        c_wide   = ({8'b0, mag} << UP_SH) >> DN_SH;
        c_next   = (c_wide > 34'd65536) ? 17'd65536 : c_wide[16:0];
    end

    logic        v1_reg;
    logic [15:0] ni1_reg;
    logic [15:0] nt1_reg;
    logic [16:0] c1_reg;

    // ---------------- stage 2: squares and ni*c ----------------
    logic        v2_reg;
    logic [31:0] nisq2_reg;
    logic [31:0] ntsq2_reg;
    logic [33:0] csq2_reg;
    logic [32:0] p1_2_reg;
    logic [16:0] c2_reg;
    logic [15:0] ni2_reg;

    // ---------------- stage 3: sine squared ----------------
    logic        v3_reg;
    logic [32:0] s2_3_reg;
    logic [31:0] nisq3_reg;
    logic [31:0] ntsq3_reg;
    logic [32:0] p1_3_reg;
    logic [16:0] c3_reg;
    logic [15:0] ni3_reg;

    // ---------------- stage 4: snell terms ----------------
    logic        v4_reg;
    logic [63:0] lhs4_reg;
    logic [63:0] rhs4_reg;
    logic [32:0] p1_4_reg;
    logic [48:0] p2_4_reg;
    logic [15:0] ni4_reg;

    // ---------------- stage 5: tir decision ----------------
    logic        v5_reg;
    logic        tir5_reg;
    logic [63:0] diff5_reg;
    logic [32:0] p1_5_reg;
    logic [48:0] p2_5_reg;
    logic [15:0] ni5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= cos_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ni1_reg <= entering ? eta_i_reg : eta_t_reg;
            nt1_reg <= entering ? eta_t_reg : eta_i_reg;
            c1_reg  <= c_next;

            nisq2_reg <= ni1_reg * ni1_reg;
            ntsq2_reg <= nt1_reg * nt1_reg;
            csq2_reg  <= c1_reg * c1_reg;
            p1_2_reg  <= {17'b0, ni1_reg} * {16'b0, c1_reg};
            c2_reg    <= c1_reg;
            ni2_reg   <= ni1_reg;

            s2_3_reg  <= 33'h1_0000_0000 - csq2_reg[32:0];
            nisq3_reg <= nisq2_reg;
            ntsq3_reg <= ntsq2_reg;
            p1_3_reg  <= p1_2_reg;
            c3_reg    <= c2_reg;
            ni3_reg   <= ni2_reg;

            // s2 is exactly 2^32 only for a zero cosine
            if (s2_3_reg[32])
                lhs4_reg <= {nisq3_reg, 32'b0};
            else
                lhs4_reg <= {32'b0, nisq3_reg} * {32'b0, s2_3_reg[31:0]};
            rhs4_reg <= {ntsq3_reg, 32'b0};
            p2_4_reg <= {17'b0, ntsq3_reg} * {32'b0, c3_reg};
            p1_4_reg <= p1_3_reg;
            ni4_reg  <= ni3_reg;

            tir5_reg  <= (lhs4_reg >= rhs4_reg);
            diff5_reg <= rhs4_reg - lhs4_reg;
            p1_5_reg  <= p1_4_reg;
            p2_5_reg  <= p2_4_reg;
            ni5_reg   <= ni4_reg;
        end
    end

    // ---------------- square root: g = nt * transmitted cosine ----------------
    logic [31:0] g_root;
    sqrt_sb_t    sq_sb_reg [SQRT_STAGES];

    fdr_isqrt u_isqrt (
        .clk      (clk),
        .en       (en),
        .radicand (diff5_reg),
        .root     (g_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SQRT_STAGES; i++)
                sq_sb_reg[i] <= '0;
        end
        else if (en)
        begin
            sq_sb_reg[0] <= '{valid: v5_reg, tir: tir5_reg, p1: p1_5_reg,
                              p2: p2_5_reg, ni: ni5_reg};
            for (int i = 1; i < SQRT_STAGES; i++)
                sq_sb_reg[i] <= sq_sb_reg[i-1];
        end
    end

    // ---------------- stage 6: ni*g ----------------
    logic        v6_reg;
    logic        tir6_reg;
    logic [31:0] g6_reg;
    logic [47:0] m2_6_reg;
    logic [32:0] p1_6_reg;
    logic [48:0] p2_6_reg;

    // ---------------- stage 7: ratio numerators and denominators ----------------
    logic        v7_reg;
    logic        tir7_reg;
    logic [33:0] n1_7_reg;
    logic [33:0] d1_7_reg;
    logic [49:0] n2_7_reg;
    logic [49:0] d2_7_reg;

    // ---------------- stage 8: normalizing shift amounts ----------------
    logic        v8_reg;
    logic        tir8_reg;
    logic [33:0] n1_8_reg;
    logic [33:0] d1_8_reg;
    logic [49:0] n2_8_reg;
    logic [49:0] d2_8_reg;
    logic [1:0]  sh1_8_reg;
    logic [4:0]  sh2_8_reg;
    logic        z1_8_reg;
    logic        z2_8_reg;

    // ---------------- stage 9: shifted operands into the dividers ----------------
    logic        v9_reg;
    logic        tir9_reg;
    logic        z1_9_reg;
    logic        z2_9_reg;
    logic [31:0] n1_9_reg;
    logic [31:0] d1_9_reg;
    logic [31:0] n2_9_reg;
    logic [31:0] d2_9_reg;

    logic [1:0]  sh1_next;
    logic [4:0]  sh2_next;
    sqrt_sb_t    sq_out;

    assign sq_out = sq_sb_reg[SQRT_STAGES-1];

    always_comb
    begin
        sh1_next = d1_7_reg[33] ? 2'd2 : (d1_7_reg[32] ? 2'd1 : 2'd0);
        sh2_next = '0;
        for (int j = 32; j < 50; j++)
        begin
            if (d2_7_reg[j])
                sh2_next = 5'(j - 31);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            v8_reg <= 1'b0;
            v9_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= sq_out.valid;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tir6_reg <= sq_out.tir;
            g6_reg   <= g_root;
            m2_6_reg <= {32'b0, sq_out.ni} * {16'b0, g_root};
            p1_6_reg <= sq_out.p1;
            p2_6_reg <= sq_out.p2;

            tir7_reg <= tir6_reg;
            if (p1_6_reg > {1'b0, g6_reg})
                n1_7_reg <= {1'b0, p1_6_reg - {1'b0, g6_reg}};
            else
                n1_7_reg <= {1'b0, {1'b0, g6_reg} - p1_6_reg};
            d1_7_reg <= {1'b0, p1_6_reg} + {2'b0, g6_reg};
            if (p2_6_reg > {1'b0, m2_6_reg})
                n2_7_reg <= {1'b0, p2_6_reg - {1'b0, m2_6_reg}};
            else
                n2_7_reg <= {1'b0, {1'b0, m2_6_reg} - p2_6_reg};
            d2_7_reg <= {1'b0, p2_6_reg} + {2'b0, m2_6_reg};

            tir8_reg  <= tir7_reg;
            n1_8_reg  <= n1_7_reg;
            d1_8_reg  <= d1_7_reg;
            n2_8_reg  <= n2_7_reg;
            d2_8_reg  <= d2_7_reg;
            sh1_8_reg <= sh1_next;
            sh2_8_reg <= sh2_next;
            z1_8_reg  <= (d1_7_reg == '0);
            z2_8_reg  <= (d2_7_reg == '0);

            tir9_reg <= tir8_reg;
            z1_9_reg <= z1_8_reg;
            z2_9_reg <= z2_8_reg;
            n1_9_reg <= 32'(n1_8_reg >> sh1_8_reg);
            d1_9_reg <= 32'(d1_8_reg >> sh1_8_reg);
            n2_9_reg <= 32'(n2_8_reg >> sh2_8_reg);
            d2_9_reg <= 32'(d2_8_reg >> sh2_8_reg);
        end
    end

    // ---------------- dividers: perpendicular and parallel ratios ----------------
    logic [Q_W-1:0] q1_raw;
    logic [Q_W-1:0] q2_raw;
    div_sb_t        dv_sb_reg [DIV_STAGES];
    div_sb_t        dv_out;

    fdr_div u_div_perp (
        .clk (clk),
        .en  (en),
        .num (n1_9_reg),
        .den (d1_9_reg),
        .quo (q1_raw)
    );

    fdr_div u_div_par (
        .clk (clk),
        .en  (en),
        .num (n2_9_reg),
        .den (d2_9_reg),
        .quo (q2_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_STAGES; i++)
                dv_sb_reg[i] <= '0;
        end
        else if (en)
        begin
            dv_sb_reg[0] <= '{valid: v9_reg, tir: tir9_reg, z1: z1_9_reg, z2: z2_9_reg};
            for (int i = 1; i < DIV_STAGES; i++)
                dv_sb_reg[i] <= dv_sb_reg[i-1];
        end
    end

    assign dv_out = dv_sb_reg[DIV_STAGES-1];

    // ---------------- stage 10: grazing limit and clamp ----------------
    logic           v10_reg;
    logic           tir10_reg;
    logic [Q_W-1:0] q1_10_reg;
    logic [Q_W-1:0] q2_10_reg;

    // ---------------- stage 11: squares ----------------
    logic           v11_reg;
    logic           tir11_reg;
    logic [61:0]    sq1_11_reg;
    logic [61:0]    sq2_11_reg;

    // ---------------- stage 12: mean, round, saturate ----------------
    logic [62:0]    sum;
    logic [16:0]    r_round;
    logic [15:0]    refl_reg;
    logic           tir_out_reg;

    always_comb
    begin
        sum     = {1'b0, sq1_11_reg} + {1'b0, sq2_11_reg} + (63'd1 << 45);
        r_round = sum[62:46];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v10_reg       <= dv_out.valid;
            v11_reg       <= v10_reg;
            out_valid_reg <= v11_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tir10_reg <= dv_out.tir;
            q1_10_reg <= (dv_out.z1 || q1_raw > Q30_ONE) ? Q30_ONE : q1_raw;
            q2_10_reg <= (dv_out.z2 || q2_raw > Q30_ONE) ? Q30_ONE : q2_raw;

            tir11_reg  <= tir10_reg;
            sq1_11_reg <= q1_10_reg * q1_10_reg;
            sq2_11_reg <= q2_10_reg * q2_10_reg;

            tir_out_reg <= tir11_reg;
            if (tir11_reg || r_round > {1'b0, REFL_ONE})
                refl_reg <= REFL_ONE;
            else
                refl_reg <= r_round[15:0];
        end
    end

    assign refl_valid     = out_valid_reg;
    assign reflectance    = refl_reg;
    assign total_internal = tir_out_reg;

endmodule

### sv/fdr_isqrt.sv
// pipelined integer square root, one result bit per stage
module fdr_isqrt
    import fdr_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    logic [63:0] rem_reg  [SQRT_STAGES];
    logic [31:0] root_reg [SQRT_STAGES];

    genvar k;
    generate
        for (k = 0; k < SQRT_STAGES; k++)
        begin : g_stage
            localparam int BIT = SQRT_STAGES - 1 - k;
            logic [63:0] rem_in;
            logic [31:0] root_in;
            logic [64:0] trial;
            logic [63:0] rem_next;
            logic [31:0] root_next;

            if (k == 0)
            begin : g_first
                assign rem_in  = radicand;
                assign root_in = '0;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            always_comb
            begin
                trial = ({33'b0, root_in} << (BIT + 1)) | (65'd1 << (2 * BIT));
                if ({1'b0, rem_in} >= trial)
                begin
                    rem_next  = rem_in - trial[63:0];
                    root_next = root_in | (32'd1 << BIT);
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[SQRT_STAGES-1];

endmodule

### sv/fdr_div.sv
// pipelined rounded ratio n/d in q.30, one quotient bit per stage
module fdr_div
    import fdr_pkg::*;
(
    input  logic             clk,
    input  logic             en,
    input  logic [31:0]      num,
    input  logic [31:0]      den,
    output logic [Q_W-1:0]   quo
);

    logic [62:0]    dividend;
    logic [31:0]    rem_reg [DIV_STAGES];
    logic [30:0]    low_reg [DIV_STAGES];
    logic [Q_W-1:0] quo_reg [DIV_STAGES];
    logic [31:0]    den_reg [DIV_STAGES];

    // n * 2^30 plus half the divisor for round to nearest
    assign dividend = ({31'b0, num} << 30) + {32'b0, den[31:1]};

    genvar k;
    generate
        for (k = 0; k < DIV_STAGES; k++)
        begin : g_stage
            logic [31:0]    rem_in;
            logic [30:0]    low_in;
            logic [Q_W-1:0] quo_in;
            logic [31:0]    den_in;
            logic [32:0]    part;
            logic [31:0]    rem_next;
            logic           qbit;

            if (k == 0)
            begin : g_first
                assign rem_in = dividend[62:31];
                assign low_in = dividend[30:0];
                assign quo_in = '0;
                assign den_in = den;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[k-1];
                assign low_in = low_reg[k-1];
                assign quo_in = quo_reg[k-1];
                assign den_in = den_reg[k-1];
            end

            always_comb
            begin
                part = {rem_in, low_in[30]};
                qbit = (part >= {1'b0, den_in});
                if (qbit)
                    rem_next = 32'(part - {1'b0, den_in});
                else
                    rem_next = part[31:0];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= rem_next;
                    low_reg[k] <= {low_in[29:0], 1'b0};
                    quo_reg[k] <= {quo_in[Q_W-2:0], qbit};
                    den_reg[k] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[DIV_STAGES-1];

endmodule
